// ===== hdl/bipartite_check_bfs_core_defines.svh =====
// assertion macros for the bipartite check core
// expects signals named clock and reset in the scope of each use
`ifndef BIPARTITE_CHECK_BFS_CORE_DEFINES_SVH
`define BIPARTITE_CHECK_BFS_CORE_DEFINES_SVH

// same-cycle implication
`define BCB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BCB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bcb_pkg.sv =====
// shared types and constants of the bipartite check core
// no dependencies; imported by the controller, datapath and top level
package bcb_pkg;

   // beat layout
   localparam int unsigned FIELD_W     = 9;
   localparam int unsigned FUNC_W      = 2;
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 8;

   // request kinds carried in req_tuser
   localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EVAL  = 2'd2;

   // colours held in the colour memory
   localparam logic COLOUR_WHITE = 1'b1;
   localparam logic COLOUR_BLACK = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_SCAN,
      ST_DEQ,
      ST_CUR_RD,
      ST_NB_INIT,
      ST_NB_RD,
      ST_NB_COL,
      ST_NB_CHK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic do_begin;
      logic add_read;
      logic add_write;
      logic eval_init;
      logic scan_skip;
      logic scan_start;
      logic deq_read;
      logic cur_read;
      logic cur_init;
      logic nb_read;
      logic nb_latch;
      logic nb_visit;
      logic clash;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic start_coloured;
      logic queue_empty;
      logic nbs_done;
      logic nb_coloured;
      logic colour_clash;
      logic rsp_busy;
   } status_type;

endpackage

// ===== hdl/bcb_ctrl.sv =====
// sequencing state machine of the bipartite check core
// depends on bcb_pkg for the state, command and status types
module bcb_ctrl
   import bcb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   input  status_type        status,
   output logic              req_ready,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FUNC_ADD:  state_in = ST_ADD_WR;
                  FUNC_EVAL: state_in = ST_SCAN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_WR:  state_in = ST_IDLE;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else if (!status.start_coloured) begin
               state_in = ST_DEQ;
            end
         end
         ST_DEQ:     state_in = status.queue_empty ? ST_SCAN : ST_CUR_RD;
         ST_CUR_RD:  state_in = ST_NB_INIT;
         ST_NB_INIT: state_in = ST_NB_RD;
         ST_NB_RD:   state_in = status.nbs_done ? ST_DEQ : ST_NB_COL;
         ST_NB_COL:  state_in = ST_NB_CHK;
         ST_NB_CHK: begin
            if (status.nb_coloured && status.colour_clash) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_NB_RD;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FUNC_BEGIN: cmd.do_begin  = 1'b1;
                  FUNC_ADD:   cmd.add_read  = 1'b1;
                  FUNC_EVAL:  cmd.eval_init = 1'b1;
                  default:    cmd         = '0;
               endcase
            end
         end
         ST_ADD_WR: cmd.add_write = 1'b1;
         ST_SCAN: begin
            if (!status.scan_done) begin
               cmd.scan_skip  = status.start_coloured;
               cmd.scan_start = !status.start_coloured;
            end
         end
         ST_DEQ:     cmd.deq_read = !status.queue_empty;
         ST_CUR_RD:  cmd.cur_read = 1'b1;
         ST_NB_INIT: cmd.cur_init = 1'b1;
         ST_NB_RD:   cmd.nb_read  = !status.nbs_done;
         ST_NB_COL:  cmd.nb_latch = 1'b1;
         ST_NB_CHK: begin
            cmd.nb_visit = !status.nb_coloured;
            cmd.clash    = status.nb_coloured && status.colour_clash;
         end
         ST_FINISH:  cmd.rsp_load = !status.rsp_busy;
         default:    cmd = '0;
      endcase
   end

endmodule

// ===== hdl/bcb_datapath.sv =====
// memories, counters and result register of the bipartite check core
// depends on bcb_pkg; driven by bcb_ctrl through cmd_type and status_type
module bcb_datapath
   import bcb_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_DEGREE   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [FIELD_W-1:0] req_vertex_count,
   input  logic [FIELD_W-1:0] req_vertex,
   input  logic [FIELD_W-1:0] req_neighbour,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_bipartite,
   output logic               rsp_load_error
);

   localparam int VI        = $clog2(MAX_VERTICES);
   localparam int CW        = $clog2(MAX_VERTICES + 2);
   localparam int QW        = $clog2(MAX_VERTICES + 1);
   localparam int DW        = $clog2(MAX_DEGREE + 1);
   localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;
   localparam int AW        = $clog2(ADJ_DEPTH);

   function automatic logic [VI-1:0] vidx(input logic [FIELD_W-1:0] id);
      vidx = VI'(32'(id) - 32'd1);
   endfunction

   function automatic logic in_range(input logic [FIELD_W-1:0] id, input logic [CW-1:0] size);
      in_range = (id != '0) && (32'(id) <= 32'(size));
   endfunction

   function automatic logic [AW-1:0] adj_addr(input logic [VI-1:0] v, input logic [DW-1:0] d);
      adj_addr = AW'(32'(v) * 32'(MAX_DEGREE) + 32'(d));
   endfunction

   // memories
   logic [VI-1:0] adj_mem    [ADJ_DEPTH];
   logic [DW-1:0] deg_mem    [MAX_VERTICES];
   logic          colour_mem [MAX_VERTICES];
   logic [VI-1:0] queue_mem  [MAX_VERTICES];

   logic [VI-1:0] adj_rd_ff;
   logic [DW-1:0] deg_rd_ff;
   logic          deg_rd_valid_ff;
   logic          colour_rd_ff;
   logic [VI-1:0] queue_rd_ff;

   // control state
   logic [CW-1:0]           graph_size_ff, graph_size_in;
   logic                    error_ff, error_in;
   logic [MAX_VERTICES-1:0] deg_valid_ff, deg_valid_in;
   logic [MAX_VERTICES-1:0] colour_valid_ff, colour_valid_in;
   logic [CW-1:0]           start_scan_ff, start_scan_in;
   logic [QW-1:0]           head_ff, head_in;
   logic [QW-1:0]           tail_ff, tail_in;
   logic                    bip_ff, bip_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [VI-1:0] add_v_ff, add_v_in;
   logic [VI-1:0] add_nb_ff, add_nb_in;
   logic          add_ok_ff, add_ok_in;
   logic [VI-1:0] cur_ff, cur_in;
   logic [DW-1:0] cur_deg_ff, cur_deg_in;
   logic          cur_colour_ff, cur_colour_in;
   logic [DW-1:0] d_ff, d_in;
   logic [VI-1:0] nb_ff, nb_in;
   logic          nb_coloured_ff, nb_coloured_in;
   logic          rsp_bip_ff, rsp_bip_in;
   logic          rsp_err_ff, rsp_err_in;

   logic [DW-1:0] deg_now;
   logic          add_fits;
   logic [VI-1:0] scan_idx;
   logic [CW-1:0] size_sat;
   logic [VI-1:0] deg_raddr;
   logic [VI-1:0] colour_raddr;
   logic [VI-1:0] colour_waddr;
   logic          colour_wdata;
   logic [VI-1:0] queue_waddr;
   logic [VI-1:0] queue_wdata;

   // unwritten degree slots read as zero
   assign deg_now  = deg_rd_valid_ff ? deg_rd_ff : '0;
   assign add_fits = add_ok_ff && (32'(deg_now) < 32'(MAX_DEGREE));
   assign scan_idx = VI'(32'(start_scan_ff) - 32'd1);
   assign size_sat = (32'(req_vertex_count) > 32'(MAX_VERTICES)) ?
                     CW'(MAX_VERTICES) : CW'(req_vertex_count);

   assign deg_raddr    = cmd.add_read ? vidx(req_vertex) : queue_rd_ff;
   assign colour_raddr = cmd.nb_latch ? adj_rd_ff : queue_rd_ff;
   assign colour_waddr = cmd.scan_start ? scan_idx : nb_ff;
   assign colour_wdata = cmd.scan_start ? COLOUR_WHITE :
                         ((cur_colour_ff == COLOUR_WHITE) ? COLOUR_BLACK : COLOUR_WHITE);
   assign queue_waddr  = cmd.scan_start ? '0 : tail_ff[VI-1:0];
   assign queue_wdata  = cmd.scan_start ? scan_idx : nb_ff;

   always_ff @(posedge clock) begin
      if (cmd.add_write && add_fits) begin
         adj_mem[adj_addr(add_v_ff, deg_now)] <= add_nb_ff;
      end
      adj_rd_ff <= adj_mem[adj_addr(cur_ff, d_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_write && add_fits) begin
         deg_mem[add_v_ff] <= DW'(32'(deg_now) + 32'd1);
      end
      deg_rd_ff       <= deg_mem[deg_raddr];
      deg_rd_valid_ff <= deg_valid_ff[deg_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start || cmd.nb_visit) begin
         colour_mem[colour_waddr] <= colour_wdata;
      end
      colour_rd_ff <= colour_mem[colour_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start || cmd.nb_visit) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      queue_rd_ff <= queue_mem[head_ff[VI-1:0]];
   end

   always_comb begin
      graph_size_in   = graph_size_ff;
      error_in        = error_ff;
      deg_valid_in    = deg_valid_ff;
      colour_valid_in = colour_valid_ff;
      start_scan_in   = start_scan_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      bip_in          = bip_ff;
      add_v_in        = add_v_ff;
      add_nb_in       = add_nb_ff;
      add_ok_in       = add_ok_ff;
      cur_in          = cur_ff;
      cur_deg_in      = cur_deg_ff;
      cur_colour_in   = cur_colour_ff;
      d_in            = d_ff;
      nb_in           = nb_ff;
      nb_coloured_in  = nb_coloured_ff;
      rsp_bip_in      = rsp_bip_ff;
      rsp_err_in      = rsp_err_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (cmd.do_begin) begin
         graph_size_in = size_sat;
         error_in      = 1'b0;
         deg_valid_in  = '0;
      end
      if (cmd.add_read) begin
         add_v_in  = vidx(req_vertex);
         add_nb_in = vidx(req_neighbour);
         add_ok_in = in_range(req_vertex, graph_size_ff) &&
                     in_range(req_neighbour, graph_size_ff);
      end
      if (cmd.add_write) begin
         if (add_fits) begin
            deg_valid_in[add_v_ff] = 1'b1;
         end else begin
            error_in = 1'b1;
         end
      end
      if (cmd.eval_init) begin
         start_scan_in   = CW'(1);
         bip_in          = 1'b1;
         colour_valid_in = '0;
      end
      if (cmd.scan_skip) begin
         start_scan_in = start_scan_ff + 1'b1;
      end
      // new walk: colour the start vertex white and seed the queue
      if (cmd.scan_start) begin
         start_scan_in             = start_scan_ff + 1'b1;
         colour_valid_in[scan_idx] = 1'b1;
         head_in                   = '0;
         tail_in                   = QW'(1);
      end
      if (cmd.deq_read) begin
         head_in = head_ff + 1'b1;
      end
      if (cmd.cur_read) begin
         cur_in = queue_rd_ff;
      end
      if (cmd.cur_init) begin
         cur_deg_in    = deg_now;
         cur_colour_in = colour_rd_ff;
         d_in          = '0;
      end
      if (cmd.nb_read) begin
         d_in = d_ff + 1'b1;
      end
      if (cmd.nb_latch) begin
         nb_in          = adj_rd_ff;
         nb_coloured_in = colour_valid_ff[adj_rd_ff];
      end
      if (cmd.nb_visit) begin
         colour_valid_in[nb_ff] = 1'b1;
         tail_in                = tail_ff + 1'b1;
      end
      if (cmd.clash) begin
         bip_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_bip_in   = bip_ff;
         rsp_err_in   = error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         graph_size_ff   <= '0;
         error_ff        <= 1'b0;
         deg_valid_ff    <= '0;
         colour_valid_ff <= '0;
         start_scan_ff   <= CW'(1);
         head_ff         <= '0;
         tail_ff         <= '0;
         bip_ff          <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         graph_size_ff   <= graph_size_in;
         error_ff        <= error_in;
         deg_valid_ff    <= deg_valid_in;
         colour_valid_ff <= colour_valid_in;
         start_scan_ff   <= start_scan_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         bip_ff          <= bip_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      add_v_ff       <= add_v_in;
      add_nb_ff      <= add_nb_in;
      add_ok_ff      <= add_ok_in;
      cur_ff         <= cur_in;
      cur_deg_ff     <= cur_deg_in;
      cur_colour_ff  <= cur_colour_in;
      d_ff           <= d_in;
      nb_ff          <= nb_in;
      nb_coloured_ff <= nb_coloured_in;
      rsp_bip_ff     <= rsp_bip_in;
      rsp_err_ff     <= rsp_err_in;
   end

   assign status.scan_done      = (start_scan_ff > graph_size_ff);
   assign status.start_coloured = colour_valid_ff[scan_idx];
   assign status.queue_empty    = (head_ff == tail_ff);
   assign status.nbs_done       = (d_ff == cur_deg_ff);
   assign status.nb_coloured    = nb_coloured_ff;
   assign status.colour_clash   = (colour_rd_ff == cur_colour_ff);
   assign status.rsp_busy       = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bipartite  = rsp_bip_ff;
   assign rsp_load_error = rsp_err_ff;

endmodule

// ===== hdl/bipartite_check_bfs_core.sv =====
// bipartite check core: begin is handled in the idle state, add does a degree memory read, then a write
// evaluate: scans the n vertices and walks the m stored entries of the k components, with
// the sequencer reading each adjacency entry through registered memories in ST_NB_RD, ST_NB_COL, ST_NB_CHK
// ST_FINISH loads the result once no earlier one is pending; one request is worked at a time
// synchronous active-high reset; the degree and colour stores clear at once through valid bits,
// so no clearing pass is needed and the core takes a request in the first cycle after reset
`include "bipartite_check_bfs_core_defines.svh"

module bipartite_check_bfs_core
   import bcb_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_DEGREE   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request beats
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [8:0] vertex_count, [17:9] vertex, [26:18] neighbour, [31:27] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] func
   input  logic [FUNC_W-1:0]      req_tuser,
   // result beats
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] bipartite, [1] load_error, [7:2] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_bipartite;
   logic       rsp_load_error;

   // controller: one state per memory access of the walk
   bcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // datapath: adjacency, degree, colour and queue memories plus the result register
   bcb_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_vertex_count (req_tdata[FIELD_W-1:0]),
      .req_vertex       (req_tdata[2*FIELD_W-1:FIELD_W]),
      .req_neighbour    (req_tdata[3*FIELD_W-1:2*FIELD_W]),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_bipartite    (rsp_bipartite),
      .rsp_load_error   (rsp_load_error)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-2){1'b0}}, rsp_load_error, rsp_bipartite};

   // an evaluate beat always leaves the core busy for at least the next cycle
   `BCB_ASSERT_NEXT(a_eval_goes_busy, req_tvalid && req_tready && (req_tuser == FUNC_EVAL), !req_tready, "evaluate did not start a walk")
   // a result only appears after the controller loads it
   `BCB_ASSERT_NOW(a_rsp_from_load, $rose(rsp_tvalid), $past(cmd.rsp_load), "result beat without a load")
   // a pending result is never overwritten
   `BCB_ASSERT_NOW(a_no_overwrite, cmd.rsp_load, !(rsp_tvalid && !rsp_tready), "pending result overwritten")

endmodule
